@@ design/fog_range_adjust_table_core_defines.svh @@
// Assertion helpers shared by the fog range table RTL
`ifndef FOG_RANGE_ADJUST_TABLE_CORE_DEFINES_SVH
`define FOG_RANGE_ADJUST_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define FRAT_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRAT_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/fog_rat_pkg.sv @@
package fog_rat_pkg;

  localparam int IDX_W = 4;

  localparam logic [31:0] F_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F_MONE = 32'hBF80_0000;
  localparam logic [31:0] F_TWO  = 32'h4000_0000;
  localparam logic [31:0] F_256  = 32'h4380_0000;
  localparam logic [31:0] F_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] F_INF  = 32'h7F80_0000;
  localparam logic [11:0] RANGE_MASK = 12'hFFF;

  localparam logic OP_DIV  = 1'b0;
  localparam logic OP_SQRT = 1'b1;

  localparam logic [4:0] DS_ITERS = 5'd26;

  typedef struct packed {
    logic               s;
    logic signed [9:0]  e;
    logic [23:0]        m;
  } unp_t;

  typedef struct packed {
    logic [31:0] side;
    logic [31:0] scale;
    logic [31:0] nn;
  } params_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [11:0]      val;
    logic             bad;
    logic             last;
  } result_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // finite nonzero operand -> normalized significand with hidden one at bit 23
  function automatic unp_t f_unpack(input logic [31:0] x);
    unp_t u;
    logic [4:0] lz;
    lz = 5'd0;
    u.s = x[31];
    if (x[30:23] == 8'd0) begin
      for (int k = 0; k <= 22; k++) begin
        if (x[k]) lz = 5'(23 - k);
      end
      u.m = {1'b0, x[22:0]} << lz;
      u.e = -10'sd126 - $signed({5'b0, lz});
    end else begin
      u.m = {1'b1, x[22:0]};
      u.e = $signed({2'b0, x[30:23]}) - 10'sd127;
    end
    return u;
  endfunction

  // m[26] is the leading one, m[2:1] guard/round, m[0] sticky
  function automatic logic [31:0] fp_round(input logic s, input logic signed [9:0] e,
                                           input logic [26:0] m);
    logic signed [10:0] be;
    logic [10:0] shv;
    logic [5:0]  sh;
    logic [53:0] w;
    logic [26:0] t;
    logic [9:0]  bexp;
    logic        up;
    logic [32:0] bits;
    be = 11'(e) + 11'sd127;
    if (be <= 11'sd0) begin
      shv  = 11'(11'sd1 - be);
      sh   = (shv > 11'd28) ? 6'd28 : shv[5:0];
      w    = {m, 27'b0} >> sh;
      t    = {w[53:28], w[27] | (|w[26:0])};
      bexp = 10'd0;
    end else begin
      t    = m;
      bexp = be[9:0] - 10'd1;
    end
    up   = t[2] & (t[1] | t[0] | t[3]);
    bits = {bexp, 23'b0} + {9'b0, t[26:3]} + {32'b0, up};
    if (bits[32:23] >= 10'd255) return {s, F_INF[30:0]};
    return {s, bits[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    unp_t ua, ub;
    logic [47:0] p;
    logic signed [9:0] e;
    logic [26:0] m;
    logic s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
      return F_QNAN;
    if (is_inf(a) || is_inf(b)) return {s, F_INF[30:0]};
    if (is_zero(a) || is_zero(b)) return {s, 31'd0};
    ua = f_unpack(a);
    ub = f_unpack(b);
    p  = ua.m * ub.m;
    e  = ua.e + ub.e + $signed({9'b0, p[47]});
    if (p[47]) m = {p[47:22], |p[21:0]};
    else       m = {p[46:21], |p[20:0]};
    return fp_round(s, e, m);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    unp_t ua, ub, x, y;
    logic [9:0]  d;
    logic [5:0]  sh;
    logic [53:0] w;
    logic [26:0] ax, bx, df;
    logic [27:0] sm;
    logic [4:0]  lz;
    logic [26:0] m;
    logic signed [9:0] e;
    lz = 5'd0;
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31])))
      return F_QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
    if (is_zero(a)) return b;
    if (is_zero(b)) return a;
    ua = f_unpack(a);
    ub = f_unpack(b);
    if ((ub.e > ua.e) || ((ub.e == ua.e) && (ub.m > ua.m))) begin
      x = ub; y = ua;
    end else begin
      x = ua; y = ub;
    end
    d  = $unsigned(x.e - y.e);
    sh = (d > 10'd28) ? 6'd28 : d[5:0];
    w  = {y.m, 3'b0, 27'b0} >> sh;
    ax = {x.m, 3'b0};
    bx = {w[53:28], w[27] | (|w[26:0])};
    if (x.s == y.s) begin
      sm = {1'b0, ax} + {1'b0, bx};
      if (sm[27]) begin
        m = {sm[27:2], sm[1] | sm[0]};
        e = x.e + 10'sd1;
      end else begin
        m = sm[26:0];
        e = x.e;
      end
    end else begin
      df = ax - bx;
      if (df == 27'd0) return 32'd0;
      for (int k = 0; k <= 26; k++) begin
        if (df[k]) lz = 5'(26 - k);
      end
      m = df << lz;
      e = x.e - $signed({5'b0, lz});
    end
    return fp_round(x.s, e, m);
  endfunction

  function automatic logic [31:0] u11_to_f(input logic [10:0] v);
    logic [3:0]  pos;
    logic [23:0] m;
    pos = 4'd0;
    if (v == 11'd0) return 32'd0;
    for (int k = 0; k <= 10; k++) begin
      if (v[k]) pos = 4'(k);
    end
    m = {13'b0, v} << (5'd23 - {1'b0, pos});
    return {1'b0, 8'd127 + {4'b0, pos}, m[22:0]};
  endfunction

  // low 12 bits of the integer part of a finite, nonnegative value
  function automatic logic [11:0] trunc_low12(input logic [31:0] p);
    logic [34:0] wide;
    logic [34:0] sv;
    logic [7:0]  ex;
    ex   = p[30:23];
    wide = {1'b1, p[22:0], 11'b0};
    if ((ex < 8'd127) || (ex > 8'd161)) return 12'd0;
    sv = wide >> (8'd161 - ex);
    return sv[11:0] & RANGE_MASK;
  endfunction

endpackage

@@ design/fog_rat_queue.sv @@
`include "fog_range_adjust_table_core_defines.svh"

module fog_rat_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    if (do_pop)  rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

  `FRAT_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH), "queue overfilled")

endmodule

@@ design/fog_rat_divsqrt.sv @@
`include "fog_range_adjust_table_core_defines.svh"

module fog_rat_divsqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] res
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              op_r, op_nxt;
  logic              s_r, s_nxt;
  logic signed [9:0] e_r, e_nxt;
  logic [28:0]       acc_r, acc_nxt;
  logic [25:0]       q_r, q_nxt;
  logic [23:0]       den_r, den_nxt;
  logic [51:0]       rad_r, rad_nxt;
  logic [31:0]       res_r, res_nxt;

  fog_rat_pkg::unp_t ua, ub;
  logic [24:0]       dsub;
  logic              dge;
  logic [28:0]       rem2, trial;

  assign ua    = fog_rat_pkg::f_unpack(a);
  assign ub    = fog_rat_pkg::f_unpack(b);
  assign dge   = acc_r[24:0] >= {1'b0, den_r};
  assign dsub  = acc_r[24:0] - {1'b0, den_r};
  assign rem2  = {acc_r[26:0], rad_r[51:50]};
  assign trial = {1'b0, q_r, 2'b01};
  assign done  = done_r;
  assign res   = res_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    s_nxt    = s_r;
    e_nxt    = e_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    rad_nxt  = rad_r;
    res_nxt  = res_r;
    if (start) begin
      op_nxt  = op;
      cnt_nxt = 5'd0;
      q_nxt   = '0;
      acc_nxt = '0;
      if (op == fog_rat_pkg::OP_DIV) begin
        s_nxt = a[31] ^ b[31];
        if (fog_rat_pkg::is_nan(a) || fog_rat_pkg::is_nan(b) ||
            (fog_rat_pkg::is_zero(a) && fog_rat_pkg::is_zero(b)) ||
            (fog_rat_pkg::is_inf(a) && fog_rat_pkg::is_inf(b))) begin
          res_nxt  = fog_rat_pkg::F_QNAN;
          done_nxt = 1'b1;
        end else if (fog_rat_pkg::is_inf(a) || fog_rat_pkg::is_zero(b)) begin
          res_nxt  = {a[31] ^ b[31], fog_rat_pkg::F_INF[30:0]};
          done_nxt = 1'b1;
        end else if (fog_rat_pkg::is_zero(a) || fog_rat_pkg::is_inf(b)) begin
          res_nxt  = {a[31] ^ b[31], 31'd0};
          done_nxt = 1'b1;
        end else begin
          busy_nxt = 1'b1;
          den_nxt  = ub.m;
          if (ua.m < ub.m) begin
            acc_nxt = {4'b0, ua.m, 1'b0};
            e_nxt   = ua.e - ub.e - 10'sd1;
          end else begin
            acc_nxt = {5'b0, ua.m};
            e_nxt   = ua.e - ub.e;
          end
        end
      end else begin
        s_nxt = 1'b0;
        if (fog_rat_pkg::is_nan(a)) begin
          res_nxt  = fog_rat_pkg::F_QNAN;
          done_nxt = 1'b1;
        end else if (fog_rat_pkg::is_zero(a)) begin
          res_nxt  = a;
          done_nxt = 1'b1;
        end else if (a[31]) begin
          res_nxt  = fog_rat_pkg::F_QNAN;
          done_nxt = 1'b1;
        end else if (fog_rat_pkg::is_inf(a)) begin
          res_nxt  = a;
          done_nxt = 1'b1;
        end else begin
          busy_nxt = 1'b1;
          // even exponent so the root exponent is exact
          if (ua.e[0]) begin
            rad_nxt = {ua.m, 1'b0, 27'b0};
            e_nxt   = (ua.e - 10'sd1) >>> 1;
          end else begin
            rad_nxt = {1'b0, ua.m, 27'b0};
            e_nxt   = ua.e >>> 1;
          end
        end
      end
    end else if (busy_r) begin
      if (cnt_r == fog_rat_pkg::DS_ITERS) begin
        res_nxt  = fog_rat_pkg::fp_round(s_r, e_r, {q_r, |acc_r});
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 5'd1;
        if (op_r == fog_rat_pkg::OP_DIV) begin
          acc_nxt = {4'b0, (dge ? dsub[23:0] : acc_r[23:0]), 1'b0};
          q_nxt   = {q_r[24:0], dge};
        end else begin
          rad_nxt = {rad_r[49:0], 2'b0};
          if (rem2 >= trial) begin
            acc_nxt = rem2 - trial;
            q_nxt   = {q_r[24:0], 1'b1};
          end else begin
            acc_nxt = rem2;
            q_nxt   = {q_r[24:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    op_r  <= op_nxt;
    s_r   <= s_nxt;
    e_r   <= e_nxt;
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    rad_r <= rad_nxt;
    res_r <= res_nxt;
  end

  `FRAT_ASSERT_IMPL(a_no_restart, clk, rst_n, busy_r, !start, "start while unit busy")
  `FRAT_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r, "done held over two cycles")

endmodule

@@ design/fog_rat_front.sv @@
module fog_rat_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [10:0]           in_screen_width,
  input  logic [31:0]           in_proj_m00,
  input  logic [31:0]           in_proj_m02,
  input  logic [31:0]           in_proj_m03,
  input  logic [31:0]           in_proj_m22,
  input  logic [31:0]           in_proj_m23,
  input  logic [31:0]           in_proj_m33,
  output logic                  mid_push,
  output fog_rat_pkg::params_t  mid_data,
  input  logic                  mid_full
);

  localparam logic [3:0] F_IDLE = 4'd0;
  localparam logic [3:0] F_T1   = 4'd1;
  localparam logic [3:0] F_DN   = 4'd2;
  localparam logic [3:0] F_WN   = 4'd3;
  localparam logic [3:0] F_T2   = 4'd4;
  localparam logic [3:0] F_T3   = 4'd5;
  localparam logic [3:0] F_DS   = 4'd6;
  localparam logic [3:0] F_WS   = 4'd7;
  localparam logic [3:0] F_DW   = 4'd8;
  localparam logic [3:0] F_WW   = 4'd9;
  localparam logic [3:0] F_PUSH = 4'd10;

  logic [3:0]  state_r, state_nxt;
  logic        hold_v_r, hold_v_nxt;
  logic [10:0] w_r;
  logic [31:0] m00_r, m02_r, m03_r, m22_r, m23_r;
  logic        persp_r;
  logic [31:0] tmp_r, tmp_nxt, near_r, near_nxt, nn_r, nn_nxt;
  logic [31:0] side_r, side_nxt, scale_r, scale_nxt;
  logic        accept;

  logic        ds_start, ds_op, ds_done;
  logic [31:0] ds_a, ds_b, ds_res;

  assign full     = hold_v_r;
  assign accept   = push && !hold_v_r;
  assign mid_data = '{side: side_r, scale: scale_r, nn: nn_r};

  fog_rat_divsqrt u_ds (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ds_start),
    .op    (ds_op),
    .a     (ds_a),
    .b     (ds_b),
    .done  (ds_done),
    .res   (ds_res)
  );

  always_comb begin
    state_nxt  = state_r;
    hold_v_nxt = hold_v_r;
    tmp_nxt    = tmp_r;
    near_nxt   = near_r;
    nn_nxt     = nn_r;
    side_nxt   = side_r;
    scale_nxt  = scale_r;
    ds_start   = 1'b0;
    ds_op      = fog_rat_pkg::OP_DIV;
    ds_a       = tmp_r;
    ds_b       = m00_r;
    mid_push   = 1'b0;
    if (accept) hold_v_nxt = 1'b1;
    case (state_r)
      F_IDLE: if (hold_v_r) state_nxt = F_T1;
      F_T1: begin
        tmp_nxt   = persp_r ? fog_rat_pkg::fp_add(m22_r, fog_rat_pkg::F_MONE)
                            : fog_rat_pkg::fp_add(fog_rat_pkg::F_ONE, m23_r);
        state_nxt = F_DN;
      end
      F_DN: begin
        ds_start  = 1'b1;
        ds_a      = persp_r ? m23_r : tmp_r;
        ds_b      = persp_r ? tmp_r : m22_r;
        state_nxt = F_WN;
      end
      F_WN: if (ds_done) begin
        near_nxt  = ds_res;
        state_nxt = F_T2;
      end
      F_T2: begin
        if (persp_r) tmp_nxt = fog_rat_pkg::fp_add(fog_rat_pkg::F_ONE, m02_r);
        else         tmp_nxt = fog_rat_pkg::fp_add(m03_r, fog_rat_pkg::F_MONE)
                               ^ 32'h8000_0000;
        nn_nxt    = fog_rat_pkg::fp_mul(near_r, near_r);
        state_nxt = F_T3;
      end
      F_T3: begin
        if (persp_r) tmp_nxt = fog_rat_pkg::fp_mul(near_r, tmp_r);
        state_nxt = F_DS;
      end
      F_DS: begin
        ds_start  = 1'b1;
        state_nxt = F_WS;
      end
      F_WS: if (ds_done) begin
        side_nxt  = ds_res;
        state_nxt = F_DW;
      end
      F_DW: begin
        ds_start  = 1'b1;
        ds_a      = fog_rat_pkg::F_TWO;
        ds_b      = fog_rat_pkg::u11_to_f(w_r);
        state_nxt = F_WW;
      end
      F_WW: if (ds_done) begin
        scale_nxt = ds_res;
        state_nxt = F_PUSH;
      end
      F_PUSH: if (!mid_full) begin
        mid_push   = 1'b1;
        hold_v_nxt = 1'b0;
        state_nxt  = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w_r     <= in_screen_width;
      m00_r   <= in_proj_m00;
      m02_r   <= in_proj_m02;
      m03_r   <= in_proj_m03;
      m22_r   <= in_proj_m22;
      m23_r   <= in_proj_m23;
      persp_r <= (in_proj_m33[30:0] == 31'd0);
    end
    tmp_r   <= tmp_nxt;
    near_r  <= near_nxt;
    nn_r    <= nn_nxt;
    side_r  <= side_nxt;
    scale_r <= scale_nxt;
  end

endmodule

@@ design/fog_rat_back.sv @@
`include "fog_range_adjust_table_core_defines.svh"

module fog_rat_back #(
  parameter int TABLE_ENTRIES = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  mid_empty,
  input  fog_rat_pkg::params_t  mid_data,
  output logic                  mid_pop,
  output logic                  res_push,
  output fog_rat_pkg::result_t  res_data,
  input  logic                  res_full
);

  localparam int IW = fog_rat_pkg::IDX_W;

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_XS   = 4'd1;
  localparam logic [3:0] B_XD   = 4'd2;
  localparam logic [3:0] B_SQ   = 4'd3;
  localparam logic [3:0] B_DIV  = 4'd4;
  localparam logic [3:0] B_WDIV = 4'd5;
  localparam logic [3:0] B_ADD  = 4'd6;
  localparam logic [3:0] B_SQRT = 4'd7;
  localparam logic [3:0] B_WSQ  = 4'd8;
  localparam logic [3:0] B_SCL  = 4'd9;
  localparam logic [3:0] B_OUT  = 4'd10;

  logic [3:0]            state_r, state_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  fog_rat_pkg::params_t  par_r, par_nxt;
  logic [31:0]           x_r, x_nxt;
  logic                  last, bad;
  logic [31:0]           xi;

  logic        ds_start, ds_op, ds_done;
  logic [31:0] ds_a, ds_b, ds_res;

  fog_rat_divsqrt u_ds (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ds_start),
    .op    (ds_op),
    .a     (ds_a),
    .b     (ds_b),
    .done  (ds_done),
    .res   (ds_res)
  );

  assign last = (idx_r == IW'(TABLE_ENTRIES - 1));
  assign xi   = fog_rat_pkg::u11_to_f({1'b0, {1'b0, idx_r} + 5'd1, 5'b0});
  // negative zero is not below zero
  assign bad  = fog_rat_pkg::is_nan(x_r) || (x_r[30:23] == 8'hFF) ||
                (x_r[31] && !fog_rat_pkg::is_zero(x_r));

  assign res_data = '{idx:  idx_r,
                      val:  bad ? 12'd0 : fog_rat_pkg::trunc_low12(x_r),
                      bad:  bad,
                      last: last};

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    par_nxt   = par_r;
    x_nxt     = x_r;
    mid_pop   = 1'b0;
    res_push  = 1'b0;
    ds_start  = 1'b0;
    ds_op     = fog_rat_pkg::OP_DIV;
    ds_a      = x_r;
    ds_b      = par_r.nn;
    case (state_r)
      B_IDLE: if (!mid_empty) begin
        par_nxt   = mid_data;
        mid_pop   = 1'b1;
        idx_nxt   = '0;
        state_nxt = B_XS;
      end
      B_XS: begin
        x_nxt     = fog_rat_pkg::fp_mul(xi, par_r.scale);
        state_nxt = B_XD;
      end
      B_XD: begin
        x_nxt     = fog_rat_pkg::fp_mul(x_r, par_r.side);
        state_nxt = B_SQ;
      end
      B_SQ: begin
        x_nxt     = fog_rat_pkg::fp_mul(x_r, x_r);
        state_nxt = B_DIV;
      end
      B_DIV: begin
        ds_start  = 1'b1;
        state_nxt = B_WDIV;
      end
      B_WDIV: if (ds_done) begin
        x_nxt     = ds_res;
        state_nxt = B_ADD;
      end
      B_ADD: begin
        x_nxt     = fog_rat_pkg::fp_add(fog_rat_pkg::F_ONE, x_r);
        state_nxt = B_SQRT;
      end
      B_SQRT: begin
        ds_start  = 1'b1;
        ds_op     = fog_rat_pkg::OP_SQRT;
        state_nxt = B_WSQ;
      end
      B_WSQ: if (ds_done) begin
        x_nxt     = ds_res;
        state_nxt = B_SCL;
      end
      B_SCL: begin
        x_nxt     = fog_rat_pkg::fp_mul(fog_rat_pkg::F_256, x_r);
        state_nxt = B_OUT;
      end
      B_OUT: if (!res_full) begin
        res_push = 1'b1;
        if (last) begin
          state_nxt = B_IDLE;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = B_XS;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    par_r <= par_nxt;
    x_r   <= x_nxt;
  end

  `FRAT_ASSERT_IMPL(a_idx_range, clk, rst_n, state_r != B_IDLE,
                    idx_r <= IW'(TABLE_ENTRIES - 1), "entry index past table end")

endmodule

@@ design/fog_range_adjust_table_core.sv @@
// Fog range-adjust table: one input item gives TABLE_ENTRIES result items.
// Front: three divides in turn on its own divide/sqrt unit; it takes a new item only once
// the last has gone to the middle queue. Back: one divide and one square root per entry, on
// its own unit, entries one after another; a zero, inf or NaN operand ends its divide or
// root without iterating.
// Reset (rst_n low, synchronous) empties both queues and returns both sequencers to idle.
module fog_range_adjust_table_core #(
  parameter int TABLE_ENTRIES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [10:0] in_screen_width,
  input  logic [31:0] in_proj_m00,
  input  logic [31:0] in_proj_m02,
  input  logic [31:0] in_proj_m03,
  input  logic [31:0] in_proj_m22,
  input  logic [31:0] in_proj_m23,
  input  logic [31:0] in_proj_m33,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_entry_index,
  output logic [11:0] out_range_value,
  output logic        out_invalid,
  output logic        out_last_entry
);

  logic                  mid_push, mid_full, mid_pop, mid_empty;
  fog_rat_pkg::params_t  mid_wdata, mid_rdata;
  logic                  res_push, res_full;
  fog_rat_pkg::result_t  res_wdata, res_rdata;

  fog_rat_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_screen_width (in_screen_width),
    .in_proj_m00     (in_proj_m00),
    .in_proj_m02     (in_proj_m02),
    .in_proj_m03     (in_proj_m03),
    .in_proj_m22     (in_proj_m22),
    .in_proj_m23     (in_proj_m23),
    .in_proj_m33     (in_proj_m33),
    .mid_push        (mid_push),
    .mid_data        (mid_wdata),
    .mid_full        (mid_full)
  );

  fog_rat_queue #(
    .W     ($bits(fog_rat_pkg::params_t)),
    .DEPTH (2)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  fog_rat_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .res_push  (res_push),
    .res_data  (res_wdata),
    .res_full  (res_full)
  );

  fog_rat_queue #(
    .W     ($bits(fog_rat_pkg::result_t)),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign out_entry_index = res_rdata.idx;
  assign out_range_value = res_rdata.val;
  assign out_invalid     = res_rdata.bad;
  assign out_last_entry  = res_rdata.last;

endmodule
